/* design/cgqr_pkg.sv */
// package: types, constants and helpers for the complex givens qr core
`timescale 1ns / 1ps
package cgqr_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int FRAC_BITS = 16;

  localparam int DW        = 24;
  localparam int A_DEPTH   = ROWS * COLS;
  localparam int Q_DEPTH   = ROWS * ROWS;
  localparam int AAW       = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int QAW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int IW        = 3;
  localparam int LCW       = $clog2(A_DEPTH + 1);
  localparam int NORM_W    = 2 * DW + 2;
  localparam int SQ_STEPS  = NORM_W / 2;
  localparam int RW        = SQ_STEPS;
  localparam int NUM_W     = DW + FRAC_BITS + 1;
  localparam int PROD_W    = 2 * DW + 1;
  localparam int ACC_W     = PROD_W + 3;

  typedef logic signed [DW-1:0] dval_t;
  typedef struct packed {
    dval_t re;
    dval_t im;
  } cval_t;

  // controller -> datapath
  typedef struct packed {
    logic        load_wr;
    logic [AAW-1:0] load_addr;
    logic        q_init;
    logic [QAW-1:0] q_addr;
    logic        rd_a;
    logic [AAW-1:0] a_addr_x;
    logic [AAW-1:0] a_addr_y;
    logic        rd_q;
    logic [QAW-1:0] q_addr_x;
    logic [QAW-1:0] q_addr_y;
    logic        cap_piv;
    logic        coef_start;
    logic        upd_go;
    logic        upd_q;
    logic        emit_rd;
    logic        emit_q;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic coef_done;
  } sts_t;

  function automatic dval_t sat_floor(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] q;
    begin
      q = v >>> FRAC_BITS;
      if (q > $signed({{(ACC_W-DW){1'b0}}, {1'b0, {(DW-1){1'b1}}}}))
        sat_floor = {1'b0, {(DW-1){1'b1}}};
      else if (q < $signed({{(ACC_W-DW){1'b1}}, {1'b1, {(DW-1){1'b0}}}}))
        sat_floor = {1'b1, {(DW-1){1'b0}}};
      else
        sat_floor = q[DW-1:0];
    end
  endfunction

endpackage

/* design/cgqr_ram.sv */
// generic single-write dual-read ram with registered read
`timescale 1ns / 1ps
module cgqr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

/* design/cgqr_coef.sv */
// rotation coefficients: iterative square root and four restoring dividers
`timescale 1ns / 1ps
module cgqr_coef (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  cgqr_pkg::cval_t       a_in,
  input  cgqr_pkg::cval_t       b_in,
  output logic                  done,
  output cgqr_pkg::cval_t       c_out,
  output cgqr_pkg::cval_t       s_out
);
  import cgqr_pkg::*;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_NORM = 5'b00010,
    C_SQRT = 5'b00100,
    C_DIV  = 5'b01000,
    C_DONE = 5'b10000
  } cstate_t;

  localparam int SCW = $clog2(SQ_STEPS + 1);
  localparam int DCW = $clog2(NUM_W + 1);

  cstate_t st_r, st_nxt;
  logic [NORM_W-1:0] rem_r, rem_nxt;
  logic [NORM_W-1:0] n_r, n_nxt;
  logic [RW-1:0]     root_r, root_nxt;
  logic [SCW-1:0]    sc_r, sc_nxt;
  logic [DCW-1:0]    dc_r, dc_nxt;
  logic [NUM_W-1:0]  num_r [4];
  logic [NUM_W-1:0]  num_nxt [4];
  logic [NUM_W-1:0]  quo_r [4];
  logic [NUM_W-1:0]  quo_nxt [4];
  logic [RW:0]       drem_r [4];
  logic [RW:0]       drem_nxt [4];
  logic [3:0]        neg_r, neg_nxt;
  logic signed [DW:0] sv [4];
  logic [PROD_W-1:0] sq [4];
  logic [NORM_W+1:0] trial;
  logic [RW:0]       dtrial [4];
  logic [DW-1:0]     qv [4];

  always_comb begin
    sv[0] = {a_in.re[DW-1], a_in.re};
    sv[1] = -{a_in.im[DW-1], a_in.im};
    sv[2] = -{b_in.re[DW-1], b_in.re};
    sv[3] = {b_in.im[DW-1], b_in.im};
    for (int k = 0; k < 4; k++) begin
      sq[k] = PROD_W'(unsigned'(64'(sv[k]) * 64'(sv[k])));
      qv[k] = neg_r[k] ? DW'(-quo_r[k]) : DW'(quo_r[k]);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    root_nxt = root_r;
    sc_nxt   = sc_r;
    dc_nxt   = dc_r;
    neg_nxt  = neg_r;
    trial    = '0;
    for (int k = 0; k < 4; k++) begin
      num_nxt[k]  = num_r[k];
      quo_nxt[k]  = quo_r[k];
      drem_nxt[k] = drem_r[k];
      dtrial[k]   = '0;
    end
    done = 1'b0;
    unique case (st_r)
      C_IDLE: begin
        if (start) st_nxt = C_NORM;
      end
      C_NORM: begin
        for (int k = 0; k < 4; k++) begin
          neg_nxt[k] = sv[k][DW];
          num_nxt[k] = NUM_W'(sv[k][DW] ? -sv[k] : sv[k]) << FRAC_BITS;
        end
        n_nxt    = NORM_W'(sq[0]) + NORM_W'(sq[1]) + NORM_W'(sq[2]) + NORM_W'(sq[3]);
        rem_nxt  = '0;
        root_nxt = '0;
        sc_nxt   = '0;
        st_nxt   = C_SQRT;
      end
      C_SQRT: begin
        trial = {rem_r, n_r[NORM_W-1 -: 2]} - {{(NORM_W-RW){1'b0}}, root_r, 2'b01};
        if (!trial[NORM_W+1]) begin
          rem_nxt  = trial[NORM_W-1:0];
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[NORM_W-3:0], n_r[NORM_W-1 -: 2]};
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        n_nxt  = n_r << 2;
        sc_nxt = sc_r + SCW'(1);
        if (sc_r == SCW'(SQ_STEPS - 1)) begin
          dc_nxt = '0;
          for (int k = 0; k < 4; k++) begin
            drem_nxt[k] = '0;
            quo_nxt[k]  = '0;
          end
          st_nxt = C_DIV;
        end
      end
      C_DIV: begin
        for (int k = 0; k < 4; k++) begin
          dtrial[k] = {drem_r[k][RW-1:0], num_r[k][NUM_W-1]} - {1'b0, root_r};
          if (!dtrial[k][RW]) begin
            drem_nxt[k] = dtrial[k];
            quo_nxt[k]  = {quo_r[k][NUM_W-2:0], 1'b1};
          end else begin
            drem_nxt[k] = {drem_r[k][RW-1:0], num_r[k][NUM_W-1]};
            quo_nxt[k]  = {quo_r[k][NUM_W-2:0], 1'b0};
          end
          num_nxt[k] = num_r[k] << 1;
        end
        dc_nxt = dc_r + DCW'(1);
        if (dc_r == DCW'(NUM_W - 1)) st_nxt = C_DONE;
      end
      C_DONE: begin
        done   = 1'b1;
        st_nxt = C_IDLE;
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    if (root_r == '0) begin
      c_out.re = dval_t'(1) <<< FRAC_BITS;
      c_out.im = '0;
      s_out    = '0;
    end else begin
      c_out.re = qv[0];
      c_out.im = qv[1];
      s_out.re = qv[2];
      s_out.im = qv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= C_IDLE;
    else        st_r <= st_nxt;
    rem_r  <= rem_nxt;
    n_r    <= n_nxt;
    root_r <= root_nxt;
    sc_r   <= sc_nxt;
    dc_r   <= dc_nxt;
    neg_r  <= neg_nxt;
    for (int k = 0; k < 4; k++) begin
      num_r[k]  <= num_nxt[k];
      quo_r[k]  <= quo_nxt[k];
      drem_r[k] <= drem_nxt[k];
    end
  end
endmodule

/* design/cgqr_datapath.sv */
// datapath: matrix stores, coefficient unit and rotation update
`timescale 1ns / 1ps
module cgqr_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cgqr_pkg::cmd_t        cmd,
  input  cgqr_pkg::dval_t       in_re,
  input  cgqr_pkg::dval_t       in_im,
  output cgqr_pkg::sts_t        sts,
  output cgqr_pkg::cval_t       emit_val
);
  import cgqr_pkg::*;

  cval_t a_rd0, a_rd1, q_rd0, q_rd1;
  cval_t x_r, y_r;
  cval_t c_w, s_w, c_r, s_r;
  cval_t piv_a_r, piv_b_r;
  logic  coef_done;
  logic  a_we, q_we;
  logic [AAW-1:0] a_waddr;
  logic [QAW-1:0] q_waddr;
  cval_t a_wdata, q_wdata;
  logic  sel_v_r, sel_q_r, upd_v_r, upd_q_r, prd_v_r, prd_q_r, wr2_r;
  logic  emq_r;
  logic [AAW-1:0] ax_r, ay_r, ax_d_r, ay_d_r, pax_r, pay_r;
  logic [QAW-1:0] qx_r, qy_r, qx_d_r, qy_d_r, pqx_r, pqy_r;
  logic signed [PROD_W-1:0] p_r [16];
  logic signed [PROD_W-1:0] p_nxt [16];
  logic signed [ACC_W-1:0] acc [4];
  cval_t n1_r, n2_r;
  logic  wr1_v_r, wr_q_r;
  logic [AAW-1:0] wa1_r, wa2_r;
  logic [QAW-1:0] wq1_r, wq2_r;

  cgqr_ram #(.WIDTH(2*DW), .DEPTH(A_DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr0(cmd.a_addr_x), .raddr1(cmd.emit_rd ? cmd.a_addr_x : cmd.a_addr_y),
    .rdata0(a_rd0), .rdata1(a_rd1)
  );

  cgqr_ram #(.WIDTH(2*DW), .DEPTH(Q_DEPTH)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr0(cmd.q_addr_x), .raddr1(cmd.q_addr_y),
    .rdata0(q_rd0), .rdata1(q_rd1)
  );

  cgqr_coef u_coef (
    .clk(clk), .rst_n(rst_n), .start(cmd.coef_start),
    .a_in(piv_a_r), .b_in(piv_b_r), .done(coef_done), .c_out(c_w), .s_out(s_w)
  );

  assign sts.coef_done = coef_done;
  assign emit_val = emq_r ? q_rd0 : a_rd0;

  // products, sign pattern per target store
  always_comb begin
    p_nxt[0]  = PROD_W'(c_r.re * x_r.re);
    p_nxt[1]  = PROD_W'(c_r.im * x_r.im);
    p_nxt[2]  = PROD_W'(s_r.re * y_r.re);
    p_nxt[3]  = PROD_W'(s_r.im * y_r.im);
    p_nxt[4]  = PROD_W'(c_r.re * x_r.im);
    p_nxt[5]  = PROD_W'(c_r.im * x_r.re);
    p_nxt[6]  = PROD_W'(s_r.re * y_r.im);
    p_nxt[7]  = PROD_W'(s_r.im * y_r.re);
    p_nxt[8]  = PROD_W'(s_r.re * x_r.re);
    p_nxt[9]  = PROD_W'(s_r.im * x_r.im);
    p_nxt[10] = PROD_W'(c_r.re * y_r.re);
    p_nxt[11] = PROD_W'(c_r.im * y_r.im);
    p_nxt[12] = PROD_W'(s_r.re * x_r.im);
    p_nxt[13] = PROD_W'(s_r.im * x_r.re);
    p_nxt[14] = PROD_W'(c_r.re * y_r.im);
    p_nxt[15] = PROD_W'(c_r.im * y_r.re);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) acc[k] = '0;
    if (!prd_q_r) begin
      acc[0] = ACC_W'(p_r[0]) - ACC_W'(p_r[1]) - ACC_W'(p_r[2]) + ACC_W'(p_r[3]);
      acc[1] = ACC_W'(p_r[4]) + ACC_W'(p_r[5]) - ACC_W'(p_r[6]) - ACC_W'(p_r[7]);
      acc[2] = ACC_W'(p_r[8]) + ACC_W'(p_r[9]) + ACC_W'(p_r[10]) + ACC_W'(p_r[11]);
      acc[3] = ACC_W'(p_r[12]) - ACC_W'(p_r[13]) + ACC_W'(p_r[14]) - ACC_W'(p_r[15]);
    end else begin
      acc[0] = ACC_W'(p_r[0]) + ACC_W'(p_r[1]) - ACC_W'(p_r[2]) - ACC_W'(p_r[3]);
      acc[1] = ACC_W'(p_r[4]) - ACC_W'(p_r[5]) - ACC_W'(p_r[6]) + ACC_W'(p_r[7]);
      acc[2] = ACC_W'(p_r[8]) - ACC_W'(p_r[9]) + ACC_W'(p_r[10]) - ACC_W'(p_r[11]);
      acc[3] = ACC_W'(p_r[12]) + ACC_W'(p_r[13]) + ACC_W'(p_r[14]) + ACC_W'(p_r[15]);
    end
  end

  // write port: load, identity init, both writes of an update pair
  always_comb begin
    a_we = 1'b0; a_waddr = cmd.load_addr; a_wdata = '{re: in_re, im: in_im};
    q_we = 1'b0; q_waddr = cmd.q_addr;
    q_wdata.re = '0; q_wdata.im = '0;
    if (cmd.load_wr) begin
      a_we = 1'b1;
    end else if (wr1_v_r) begin
      if (wr_q_r) begin
        q_we = 1'b1; q_waddr = wq1_r; q_wdata = n1_r;
      end else begin
        a_we = 1'b1; a_waddr = wa1_r; a_wdata = n1_r;
      end
    end else if (wr2_r) begin
      if (wr_q_r) begin
        q_we = 1'b1; q_waddr = wq2_r; q_wdata = n2_r;
      end else begin
        a_we = 1'b1; a_waddr = wa2_r; a_wdata = n2_r;
      end
    end
    if (cmd.q_init) begin
      q_we = 1'b1;
      q_waddr = cmd.q_addr;
      q_wdata.re = (32'(cmd.q_addr) % ROWS == 32'(cmd.q_addr) / ROWS) ?
                   (dval_t'(1) <<< FRAC_BITS) : '0;
      q_wdata.im = '0;
    end
  end

  // pipeline: issue, ram read, operands, products, sums, two writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
      upd_v_r <= 1'b0;
      prd_v_r <= 1'b0;
      wr1_v_r <= 1'b0;
      wr2_r   <= 1'b0;
    end else begin
      sel_v_r <= cmd.rd_a || cmd.rd_q;
      upd_v_r <= sel_v_r;
      prd_v_r <= upd_v_r;
      wr1_v_r <= prd_v_r;
      wr2_r   <= wr1_v_r;
    end
    if (cmd.cap_piv) begin
      piv_a_r <= a_rd0;
      piv_b_r <= a_rd1;
    end
    if (coef_done) begin
      c_r <= c_w;
      s_r <= s_w;
    end
    emq_r <= cmd.emit_q;
    ax_d_r <= cmd.a_addr_x; ay_d_r <= cmd.a_addr_y;
    qx_d_r <= cmd.q_addr_x; qy_d_r <= cmd.q_addr_y;
    sel_q_r <= cmd.rd_q;
    upd_q_r <= sel_q_r;
    x_r <= sel_q_r ? q_rd0 : a_rd0;
    y_r <= sel_q_r ? q_rd1 : a_rd1;
    ax_r <= ax_d_r; ay_r <= ay_d_r; qx_r <= qx_d_r; qy_r <= qy_d_r;
    prd_q_r <= upd_q_r;
    pax_r <= ax_r; pay_r <= ay_r; pqx_r <= qx_r; pqy_r <= qy_r;
    for (int k = 0; k < 16; k++) p_r[k] <= p_nxt[k];
    if (prd_v_r) begin
      n1_r.re <= sat_floor(acc[0]);
      n1_r.im <= sat_floor(acc[1]);
      n2_r.re <= sat_floor(acc[2]);
      n2_r.im <= sat_floor(acc[3]);
      wr_q_r <= prd_q_r;
      wa1_r <= pax_r; wa2_r <= pay_r; wq1_r <= pqx_r; wq2_r <= pqy_r;
    end
  end
endmodule

/* design/cgqr_ctrl.sv */
// controller: load, identity init, rotation sequencing and result emission
`timescale 1ns / 1ps
module cgqr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output cgqr_pkg::cmd_t         cmd,
  input  cgqr_pkg::sts_t         sts,
  output logic                   emit_v,
  output logic                   emit_which,
  output logic [cgqr_pkg::IW-1:0] emit_row,
  output logic [cgqr_pkg::IW-1:0] emit_col,
  output logic                   emit_last
);
  import cgqr_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_INIT  = 9'b000000010,
    S_PRD   = 9'b000000100,
    S_PCAP  = 9'b000001000,
    S_COEF  = 9'b000010000,
    S_UPDA  = 9'b000100000,
    S_UPDQ  = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  localparam int NCOL = (COLS < ROWS - 1) ? COLS : ROWS - 1;
  localparam int EMIT_N = Q_DEPTH + A_DEPTH;
  localparam int EW = $clog2(EMIT_N + 1);

  state_t st_r, st_nxt;
  logic [LCW-1:0] lc_r, lc_nxt;
  logic [QAW-1:0] qi_r, qi_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic ph_r, ph_nxt;
  logic [2:0] dr_r, dr_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [IW-1:0] er_r, er_nxt, ec_r, ec_nxt;
  logic ev_r, ew_r, el_r;
  logic [IW-1:0] erow_r, ecol_r;
  logic [IW-1:0] ri1;

  assign busy = (st_r != S_LOAD);
  assign ri1 = i_r - IW'(1);
  assign emit_v = ev_r;
  assign emit_which = ew_r;
  assign emit_row = erow_r;
  assign emit_col = ecol_r;
  assign emit_last = el_r;

  always_comb begin
    st_nxt = st_r; lc_nxt = lc_r; qi_nxt = qi_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; dr_nxt = dr_r; ph_nxt = ph_r;
    e_nxt = e_r; er_nxt = er_r; ec_nxt = ec_r;
    cmd = '0;
    cmd.load_addr = AAW'(lc_r);
    cmd.q_addr = qi_r;
    unique case (st_r)
      S_LOAD: begin
        if (start) begin
          cmd.load_wr = 1'b1;
          if (lc_r == LCW'(A_DEPTH - 1)) begin
            lc_nxt = '0; qi_nxt = '0; st_nxt = S_INIT;
          end else begin
            lc_nxt = lc_r + LCW'(1);
          end
        end
      end
      S_INIT: begin
        cmd.q_init = 1'b1;
        qi_nxt = qi_r + QAW'(1);
        if (32'(qi_r) == Q_DEPTH - 1) begin
          j_nxt = '0; i_nxt = IW'(ROWS - 1);
          st_nxt = (NCOL > 0) ? S_PRD : S_EMIT;
          e_nxt = '0; er_nxt = '0; ec_nxt = '0;
        end
      end
      S_PRD: begin
        cmd.a_addr_x = AAW'(32'(ri1) * COLS + 32'(j_r));
        cmd.a_addr_y = AAW'(32'(i_r) * COLS + 32'(j_r));
        st_nxt = S_PCAP;
      end
      S_PCAP: begin
        cmd.cap_piv = 1'b1;
        cmd.coef_start = 1'b1;
        st_nxt = S_COEF;
      end
      S_COEF: begin
        k_nxt = '0;
        ph_nxt = 1'b0;
        if (sts.coef_done) st_nxt = S_UPDA;
      end
      // an entry pair is read only while ph_r is low, the stores have one write port
      S_UPDA: begin
        ph_nxt = !ph_r;
        if (!ph_r) begin
          cmd.rd_a = 1'b1;
          cmd.a_addr_x = AAW'(32'(ri1) * COLS + 32'(k_r));
          cmd.a_addr_y = AAW'(32'(i_r) * COLS + 32'(k_r));
        end else if (32'(k_r) == COLS - 1) begin
          k_nxt = '0; st_nxt = S_UPDQ;
        end else k_nxt = k_r + IW'(1);
      end
      S_UPDQ: begin
        ph_nxt = !ph_r;
        if (!ph_r) begin
          cmd.rd_q = 1'b1;
          cmd.q_addr_x = QAW'(32'(k_r) * ROWS + 32'(ri1));
          cmd.q_addr_y = QAW'(32'(k_r) * ROWS + 32'(i_r));
        end else if (32'(k_r) == ROWS - 1) begin
          dr_nxt = '0; st_nxt = S_DRAIN;
        end else k_nxt = k_r + IW'(1);
      end
      S_DRAIN: begin
        dr_nxt = dr_r + 3'd1;
        if (dr_r == 3'd4) begin
          if (32'(i_r) == 32'(j_r) + 1) begin
            if (32'(j_r) == NCOL - 1) st_nxt = S_EMIT;
            else begin
              j_nxt = j_r + IW'(1); i_nxt = IW'(ROWS - 1); st_nxt = S_PRD;
            end
          end else begin
            i_nxt = ri1; st_nxt = S_PRD;
          end
        end
      end
      S_EMIT: begin
        cmd.emit_rd = 1'b1;
        cmd.emit_q = (32'(e_r) < Q_DEPTH);
        cmd.q_addr_x = QAW'(32'(er_r) * ROWS + 32'(ec_r));
        cmd.a_addr_x = AAW'(32'(er_r) * COLS + 32'(ec_r));
        e_nxt = e_r + EW'(1);
        if (cmd.emit_q ? (32'(ec_r) == ROWS - 1) : (32'(ec_r) == COLS - 1)) begin
          ec_nxt = '0;
          er_nxt = (32'(er_r) == ROWS - 1) ? '0 : er_r + IW'(1);
        end else ec_nxt = ec_r + IW'(1);
        if (32'(e_r) == EMIT_N - 1) st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      lc_r <= '0;
      ev_r <= 1'b0;
      el_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      lc_r <= lc_nxt;
      ev_r <= cmd.emit_rd;
      el_r <= cmd.emit_rd && (32'(e_r) == EMIT_N - 1);
    end
    qi_r <= qi_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; dr_r <= dr_nxt;
    ph_r <= ph_nxt;
    e_r <= e_nxt; er_r <= er_nxt; ec_r <= ec_nxt;
    ew_r <= !cmd.emit_q;
    erow_r <= er_r;
    ecol_r <= ec_r;
  end
endmodule

/* design/complex_givens_qr_decomposition_core.sv */
// top level of the complex givens rotation qr decomposition core
`timescale 1ns / 1ps
// Elements of A are taken one per cycle, row-major, at each edge with start
// high and busy low. After the last one the core stays busy: it first sets Q
// to identity, then each of the 6 rotations reads the pivot pair, runs the
// coefficient unit (a norm step, NORM_W/2 = 25 square-root steps, NUM_W = 41
// divider steps and a done step), updates the entry pairs of A and then of
// Q, one entry pair at a time since each store has a single write port, and
// drains the update pipeline; last it reads out Q and R. Results come on
// out_valid one per cycle, Q row-major then R row-major; the receiver
// cannot stall and must take each item in its cycle. out_last_result marks
// the final R element, and busy is already low in that cycle.
module complex_givens_qr_decomposition_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  cgqr_pkg::dval_t         in_elem_re,
  input  cgqr_pkg::dval_t         in_elem_im,
  output logic                    out_valid,
  output logic                    out_which_matrix,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output cgqr_pkg::dval_t         out_re,
  output cgqr_pkg::dval_t         out_im,
  output logic                    out_last_result
);
  import cgqr_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  cval_t ev;

  cgqr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts),
    .emit_v(out_valid), .emit_which(out_which_matrix), .emit_row(out_row),
    .emit_col(out_col), .emit_last(out_last_result)
  );

  cgqr_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_re(in_elem_re), .in_im(in_elem_im),
    .sts(sts), .emit_val(ev)
  );

  assign out_re = ev.re;
  assign out_im = ev.im;

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> out_valid && out_which_matrix)
    else $error("last without valid r item");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> !busy)
    else $error("busy after last");
endmodule
